>>> hdl/sfr_pkg.sv
package sfr_pkg;

   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_WORD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT     = 2'd2;

   localparam logic [15:0] HEADER_WORD_RST = 16'd0;
   localparam logic [15:0] MAX_LEN_RST     = 16'd251;
   localparam logic [15:0] TIMEOUT_RST     = 16'd20;

   localparam logic [2:0] ST_NONE     = 3'd0;
   localparam logic [2:0] ST_GOOD     = 3'd1;
   localparam logic [2:0] ST_CHECKSUM = 3'd2;
   localparam logic [2:0] ST_LENGTH   = 3'd3;
   localparam logic [2:0] ST_TIMEOUT  = 3'd4;

   typedef struct packed {
      logic [15:0] header_word;
      logic [15:0] max_payload_len;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  payload_data;
      logic [15:0] byte_index;
      logic [2:0]  status;
      logic [15:0] frame_length;
   } result_type;

endpackage

>>> hdl/sfr_csr.sv
module sfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [15:0]                      wr_data,
   output sfr_pkg::cfg_type                 cfg
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_HEADER_WORD: cfg_in.header_word     = wr_data;
            CSR_MAX_LEN:     cfg_in.max_payload_len = wr_data;
            CSR_TIMEOUT:     cfg_in.timeout_ticks   = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_word     <= HEADER_WORD_RST;
         cfg_ff.max_payload_len <= MAX_LEN_RST;
         cfg_ff.timeout_ticks   <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/sfr_parse.sv
module sfr_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  sfr_pkg::cfg_type     cfg,
   input  logic                 advance,
   input  logic                 mode,
   input  logic [7:0]           rx_byte,
   output sfr_pkg::result_type  result
);
   import sfr_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_HDR   = 3'd1;
   localparam logic [2:0] PH_SUM   = 3'd2;
   localparam logic [2:0] PH_LENLO = 3'd3;
   localparam logic [2:0] PH_LENHI = 3'd4;
   localparam logic [2:0] PH_PAY   = 3'd5;

   logic [2:0]  phase_ff,   phase_in;
   logic [7:0]  exp_sum_ff, exp_sum_in;
   logic [7:0]  len_lo_ff,  len_lo_in;
   logic [15:0] pay_len_ff, pay_len_in;
   logic [15:0] remain_ff,  remain_in;
   logic [7:0]  xor_ff,     xor_in;
   logic [15:0] ticks_ff,   ticks_in;

   logic [2:0]  ph;
   logic [15:0] limit;
   logic [15:0] ticks_inc;
   logic [15:0] new_len;
   logic [15:0] remain_dec;
   logic [7:0]  xor_next;

   always_comb begin
      ph         = (phase_ff > PH_PAY) ? PH_IDLE : phase_ff;
      limit      = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
      ticks_inc  = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
      new_len    = {rx_byte, len_lo_ff};
      remain_dec = remain_ff - 16'd1;
      xor_next   = xor_ff ^ rx_byte;

      phase_in   = ph;
      exp_sum_in = exp_sum_ff;
      len_lo_in  = len_lo_ff;
      pay_len_in = pay_len_ff;
      remain_in  = remain_ff;
      xor_in     = xor_ff;
      ticks_in   = ticks_ff;
      result     = '0;

      if (mode) begin
         if (ph != PH_IDLE) begin
            if (ticks_inc >= limit) begin
               result.status       = ST_TIMEOUT;
               result.frame_length = (ph == PH_PAY) ? pay_len_ff : 16'd0;
               phase_in            = PH_IDLE;
               ticks_in            = 16'd0;
            end else begin
               ticks_in = ticks_inc;
            end
         end
      end else begin
         ticks_in = 16'd0;
         unique case (ph)
            PH_IDLE: begin
               if (rx_byte == cfg.header_word[7:0]) phase_in = PH_HDR;
            end
            PH_HDR: begin
               phase_in = (rx_byte == cfg.header_word[15:8]) ? PH_SUM : PH_IDLE;
            end
            PH_SUM: begin
               exp_sum_in = rx_byte;
               phase_in   = PH_LENLO;
            end
            PH_LENLO: begin
               len_lo_in = rx_byte;
               phase_in  = PH_LENHI;
            end
            PH_LENHI: begin
               pay_len_in = new_len;
               if (new_len > cfg.max_payload_len) begin
                  result.status       = ST_LENGTH;
                  result.frame_length = new_len;
                  phase_in            = PH_IDLE;
               end else if (new_len == 16'd0) begin
                  result.status = (exp_sum_ff == 8'd0) ? ST_GOOD : ST_CHECKSUM;
                  phase_in      = PH_IDLE;
               end else begin
                  remain_in = new_len;
                  xor_in    = 8'd0;
                  phase_in  = PH_PAY;
               end
            end
            default: begin
               result.byte_valid   = 1'b1;
               result.payload_data = rx_byte;
               result.byte_index   = pay_len_ff - remain_ff;
               xor_in              = xor_next;
               remain_in           = remain_dec;
               if (remain_dec == 16'd0) begin
                  result.status       = (xor_next == exp_sum_ff) ? ST_GOOD : ST_CHECKSUM;
                  result.frame_length = pay_len_ff;
                  phase_in            = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         exp_sum_ff <= 8'd0;
         len_lo_ff  <= 8'd0;
         pay_len_ff <= 16'd0;
         remain_ff  <= 16'd0;
         xor_ff     <= 8'd0;
         ticks_ff   <= 16'd0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         exp_sum_ff <= exp_sum_in;
         len_lo_ff  <= len_lo_in;
         pay_len_ff <= pay_len_in;
         remain_ff  <= remain_in;
         xor_ff     <= xor_in;
         ticks_ff   <= ticks_in;
      end
   end

endmodule

>>> hdl/serial_frame_receiver_xor_check_top.sv
// Serial frame receiver with XOR checksum.
// req_ channel: one transaction per received byte (req_mode = 0, req_rx_byte)
//   or per time tick (req_mode = 1). Frames are header low, header high,
//   checksum, length low, length high, then payload.
// rsp_ channel: exactly one transaction per request. Payload bytes come out
//   with rsp_byte_valid and rsp_byte_index; the last byte of a frame (or the
//   length byte / tick that ends it) carries rsp_status and rsp_frame_length.
// csr_ channel: register writes (0 header, 1 max length, 2 timeout ticks),
//   always ready. Write only while no request is outstanding; never checked.
// Latency: a response is valid the cycle after its request is accepted.
// Throughput: one request per cycle while rsp_ready is high. The parser
//   state and the response register update in the same cycle, so the single
//   response register is the only stage.
// If rsp_ready is low, the response register holds and req_ready drops
//   until it is taken; nothing is lost.
// Reset: synchronous; parser returns to header hunting, registers go to
//   header 0, max length 251, timeout 20, and the response register empties.
module serial_frame_receiver_xor_check_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_byte_valid,
   output logic [7:0]                       rsp_payload_data,
   output logic [15:0]                      rsp_byte_index,
   output logic [2:0]                       rsp_status,
   output logic [15:0]                      rsp_frame_length,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                      csr_data
);
   import sfr_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign csr_ready    = 1'b1;
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   sfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   sfr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (accept),
      .mode    (req_mode),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_valid   = rsp_ff.byte_valid;
   assign rsp_payload_data = rsp_ff.payload_data;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_status       = rsp_ff.status;
   assign rsp_frame_length = rsp_ff.frame_length;

endmodule
